// ----- sv/grid_box_smoothing_defines.svh -----
// Assertion macros shared by the grid box smoothing RTL.
// Depends on nothing; the assertions compile away when SYNTH is defined.
`ifndef GRID_BOX_SMOOTHING_DEFINES_SVH
`define GRID_BOX_SMOOTHING_DEFINES_SVH
`ifndef SYNTH
`define GBS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid box smoothing: same-cycle check failed");
`define GBS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid box smoothing: next-cycle check failed");
`else
`define GBS_ASSERT_IMP(label, clk, rst, ante, cons)
`define GBS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/gbs_pkg.sv -----
// Package for the grid box smoothing block: sizes, codes and shared types.
// Used by gbs_mean_unit and grid_box_smoothing; depends on nothing.
package gbs_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);

  localparam int OP_W        = 2;
  localparam int IDX_W       = 12;
  localparam int PASS_W      = 3;
  localparam int GRID_SIDE_W = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE  = CFG_IDX_W'(1);

  localparam logic [PASS_W-1:0]      PASS_COUNT_RESET = PASS_W'(2);
  localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RESET  = GRID_SIDE_W'(64);

  // Mean of nine: the sum is biased to a non-negative value and divided by a
  // reciprocal multiply followed by a single correction step.
  localparam int BOX_AREA     = 9;
  localparam int SUM_W        = SAMPLE_BITS + 4;
  localparam int V_W          = SAMPLE_BITS + 5;
  localparam int RECIP_SHIFT  = SAMPLE_BITS + 6;
  localparam int RECIP_W      = RECIP_SHIFT - 3;
  localparam int PROD_W       = V_W + RECIP_W;
  localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / BOX_AREA;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_FULL);
  localparam logic [V_W-1:0] MEAN_BIAS   =
    V_W'((64'(BOX_AREA) << SAMPLE_BITS) + 64'd4);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SMOOTH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tap_ctl_t;

endpackage

// ----- sv/gbs_mean_unit.sv -----
// Shared accumulate and divide-by-nine unit of the grid box smoothing block.
// Depends on gbs_pkg.
module gbs_mean_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gbs_pkg::tap_ctl_t                     tap,
  input  logic signed [gbs_pkg::SAMPLE_BITS-1:0] tap_sample,
  output logic                                  mean_valid,
  output logic signed [gbs_pkg::SAMPLE_BITS-1:0] mean
);
  import gbs_pkg::*;

  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] acc_next;
  logic signed [SUM_W-1:0] sum;
  logic                    sum_valid;
  logic [V_W-1:0]          biased;
  logic [PROD_W-1:0]       prod;
  logic [V_W-1:0]          q_est;
  logic [V_W-1:0]          v_held;
  logic                    q_valid;
  logic [V_W+3:0]          q_times9;
  logic [V_W+3:0]          remainder;
  logic [V_W-1:0]          q;

  always_comb begin
    acc_next  = tap.first ? SUM_W'(tap_sample) : acc + SUM_W'(tap_sample);
    biased    = V_W'(sum) + MEAN_BIAS;
    prod      = PROD_W'(biased) * PROD_W'(RECIP);
    q_times9  = ((V_W + 4)'(q_est) << 3) + (V_W + 4)'(q_est);
    remainder = (V_W + 4)'(v_held) - q_times9;
    q         = (remainder >= (V_W + 4)'(BOX_AREA)) ? q_est + V_W'(1) : q_est;
  end

  always_ff @(posedge clk) begin
    if (tap.valid) begin
      acc <= acc_next;
    end
    if (tap.valid && tap.last) begin
      sum <= acc_next;
    end
    q_est  <= V_W'(prod >> RECIP_SHIFT);
    v_held <= biased;
    mean   <= q[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid  <= 1'b0;
      q_valid    <= 1'b0;
      mean_valid <= 1'b0;
    end else begin
      sum_valid  <= tap.valid && tap.last;
      q_valid    <= sum_valid;
      mean_valid <= q_valid;
    end
  end

endmodule

// ----- sv/grid_box_smoothing.sv -----
// Top level of the grid box smoothing block: command sequencer and the two stores.
// Depends on gbs_pkg, gbs_mean_unit and grid_box_smoothing_defines.svh.
//
// A write item goes straight to S_FIN, and a read item goes through S_READ first.
// A smoothing item runs pass_count passes over a grid of side s (grid_side, capped at
// 64); each pass first copies the height store into the pass store through its
// read port, then handles each of the (s-2)*(s-2) interior cells, which read their
// nine neighbors one per cycle from the pass store and go through the shared
// three-stage mean unit. With no passes or a side below three it finishes like a
// write. The block takes no new item until the result of the current one is loaded
// into the output register. Both stores are uninitialized after reset.
`include "grid_box_smoothing_defines.svh"

module grid_box_smoothing (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cmd_valid,
  output logic                                   cmd_stall,
  input  logic [gbs_pkg::OP_W-1:0]               op,
  input  logic [gbs_pkg::IDX_W-1:0]              cell_index,
  input  logic signed [gbs_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic signed [gbs_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                   done_res,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import gbs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_COPY  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_TAP   = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                  state;
  logic [PASS_W-1:0]       pass_count;
  logic [GRID_SIDE_W-1:0]  grid_side;
  logic [SIDE_W-1:0]       side;
  logic [SIDE_W-1:0]       side_sat;
  logic [PASS_W-1:0]       passes_left;
  logic [ADDR_W-1:0]       copy_addr;
  logic                    copy_wr_valid;
  logic [ADDR_W-1:0]       copy_wr_addr;
  logic [SIDE_W-1:0]       cx;
  logic [SIDE_W-1:0]       cy;
  logic [1:0]              dx;
  logic [1:0]              dy;
  logic [ADDR_W-1:0]       row_base;
  logic [ADDR_W-1:0]       tap_base;
  logic                    rd_oob;
  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic                    res_done;

  logic signed [SAMPLE_BITS-1:0] height_store [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] pass_store [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] h_rdata;
  logic signed [SAMPLE_BITS-1:0] p_rdata;
  logic [ADDR_W-1:0]       h_raddr;
  logic [ADDR_W-1:0]       h_waddr;
  logic signed [SAMPLE_BITS-1:0] h_wdata;
  logic                    h_we;
  logic [ADDR_W-1:0]       p_raddr;
  logic [ADDR_W-1:0]       center_addr;

  logic                    cmd_take;
  logic                    cmd_in_range;
  logic                    res_free;
  logic                    last_col;
  logic                    last_row;
  tap_ctl_t                tap_ctl;
  logic                    mean_valid;
  logic signed [SAMPLE_BITS-1:0] mean;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    cmd_take     = cmd_valid && (state == S_IDLE);
    cmd_in_range = 32'(cell_index) < STORE_DEPTH;
    res_free     = !res_valid || !res_stall;
    side_sat     = (32'(grid_side) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(grid_side);
    last_col     = (cx == side - SIDE_W'(2));
    last_row     = (cy == side - SIDE_W'(2));
    center_addr  = row_base + ADDR_W'(side) + ADDR_W'(cx);
    p_raddr      = tap_base + ADDR_W'(cx) + ADDR_W'(dx) - ADDR_W'(1);
    h_raddr      = (state == S_IDLE) ? ADDR_W'(cell_index) : copy_addr;
    h_we         = 1'b0;
    h_waddr      = center_addr;
    h_wdata      = mean;
    if (cmd_take && (op == OP_WRITE) && cmd_in_range) begin
      h_we    = 1'b1;
      h_waddr = ADDR_W'(cell_index);
      h_wdata = sample_in;
    end else if ((state == S_WAIT) && mean_valid) begin
      h_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      height_store[h_waddr] <= h_wdata;
    end
    h_rdata <= height_store[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (copy_wr_valid) begin
      pass_store[copy_wr_addr] <= h_rdata;
    end
    p_rdata <= pass_store[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= PASS_COUNT_RESET;
      grid_side  <= GRID_SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PASS_COUNT: pass_count <= cfg_data[PASS_W-1:0];
        REG_GRID_SIDE:  grid_side  <= cfg_data[GRID_SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  gbs_mean_unit u_mean (
    .clk        (clk),
    .rst        (rst),
    .tap        (tap_ctl),
    .tap_sample (p_rdata),
    .mean_valid (mean_valid),
    .mean       (mean)
  );

  always_ff @(posedge clk) begin
    copy_wr_addr <= copy_addr;
    tap_ctl.first <= (dx == 2'd0) && (dy == 2'd0);
    tap_ctl.last  <= (dx == 2'd2) && (dy == 2'd2);
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      copy_wr_valid <= 1'b0;
      tap_ctl.valid <= 1'b0;
    end else begin
      copy_wr_valid <= (state == S_COPY);
      tap_ctl.valid <= (state == S_TAP);
      if ((state == S_FIN) && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            res_sample <= '0;
            res_done   <= (op_t'(op) != OP_NONE);
            rd_oob     <= !cmd_in_range;
            case (op_t'(op))
              OP_WRITE: state <= S_FIN;
              OP_READ:  state <= S_READ;
              OP_SMOOTH: begin
                side        <= side_sat;
                passes_left <= pass_count;
                copy_addr   <= '0;
                if ((side_sat < SIDE_W'(3)) || (pass_count == '0)) begin
                  state <= S_FIN;
                end else begin
                  state <= S_COPY;
                end
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_READ: begin
          res_sample <= rd_oob ? '0 : h_rdata;
          state      <= S_FIN;
        end
        S_COPY: begin
          if (copy_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= S_DRAIN;
          end else begin
            copy_addr <= copy_addr + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          cx       <= SIDE_W'(1);
          cy       <= SIDE_W'(1);
          dx       <= 2'd0;
          dy       <= 2'd0;
          row_base <= '0;
          tap_base <= '0;
          state    <= S_TAP;
        end
        S_TAP: begin
          if (dx == 2'd2) begin
            dx <= 2'd0;
            if (dy == 2'd2) begin
              dy       <= 2'd0;
              tap_base <= row_base;
              state    <= S_WAIT;
            end else begin
              dy       <= dy + 2'd1;
              tap_base <= tap_base + ADDR_W'(side);
            end
          end else begin
            dx <= dx + 2'd1;
          end
        end
        S_WAIT: begin
          if (mean_valid) begin
            if (last_col) begin
              cx <= SIDE_W'(1);
              if (last_row) begin
                if (passes_left == PASS_W'(1)) begin
                  state <= S_FIN;
                end else begin
                  passes_left <= passes_left - PASS_W'(1);
                  copy_addr   <= '0;
                  state       <= S_COPY;
                end
              end else begin
                cy       <= cy + SIDE_W'(1);
                row_base <= row_base + ADDR_W'(side);
                tap_base <= row_base + ADDR_W'(side);
                state    <= S_TAP;
              end
            end else begin
              cx    <= cx + SIDE_W'(1);
              state <= S_TAP;
            end
          end
        end
        S_FIN: begin
          if (res_free) begin
            sample_out <= res_sample;
            done_res   <= res_done;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GBS_ASSERT_IMP(a_mean_only_when_waiting, clk, rst, mean_valid, state == S_WAIT)
  `GBS_ASSERT_IMP(a_copy_write_in_copy, clk, rst, copy_wr_valid,
                  (state == S_COPY) || (state == S_DRAIN))
  `GBS_ASSERT_IMP(a_pass_pending, clk, rst, state == S_COPY, passes_left != '0)
  `GBS_ASSERT_NXT(a_write_finishes, clk, rst, cmd_valid && !cmd_stall && (op == OP_WRITE), state == S_FIN)

endmodule
